/* hw/rtl/mpq_pkg.sv */
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared sizes, codes and control structs for the max priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int DEPTH         = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int PAYLOAD_BITS  = 16;

  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int LEVELS = IDX_W;
  localparam int LEAVES = 1 << LEVELS;

  typedef logic [PRIORITY_BITS-1:0] pri_t;
  typedef logic [PAYLOAD_BITS-1:0]  pay_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic {
    CMD_ADD     = 1'b0,
    CMD_EXTRACT = 1'b1
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch the request fields
    logic search;  // register the winner of the compare tree
    logic exec;    // apply the request and load the result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_free;  // result register is empty or being taken
  } dp_stat_t;

endpackage

/* hw/rtl/mpq_ctrl.sv */
// ----------------------------------------------------------------------------
// mpq_ctrl
// Sequencer: accept a request, search for the winner, then execute.
// ----------------------------------------------------------------------------
module mpq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  mpq_pkg::dp_stat_t dp_stat,
  output mpq_pkg::dp_cmd_t  dp_cmd
);
  import mpq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_EXEC
  } state_t;

  state_t state;
  logic   exec_go;

  assign exec_go   = (state == S_EXEC) && dp_stat.slot_free;
  // take the next request as soon as the current one executes; hold off in reset
  assign cmd_ready = !rst && ((state == S_IDLE) || exec_go);

  assign dp_cmd.load   = cmd_valid && cmd_ready;
  assign dp_cmd.search = (state == S_SEARCH);
  assign dp_cmd.exec   = exec_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (exec_go) begin
            state <= cmd_valid ? S_SEARCH : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_to_search: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> state == S_SEARCH)
    else $error("accepted request did not enter search");

  a_search_to_exec: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |=> state == S_EXEC)
    else $error("search did not advance to execute");

endmodule

/* hw/rtl/mpq_datapath.sv */
// ----------------------------------------------------------------------------
// mpq_datapath
// Entry storage in arrival order, max-compare tree, gap close and result
// register.
// ----------------------------------------------------------------------------
module mpq_datapath (
  input  logic                clk,
  input  logic                rst,
  input  mpq_pkg::dp_cmd_t    dp_cmd,
  output mpq_pkg::dp_stat_t   dp_stat,
  input  logic                command,
  input  mpq_pkg::pri_t       priority_req,
  input  mpq_pkg::pay_t       payload,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output logic                out_valid,
  output mpq_pkg::pri_t       out_priority,
  output mpq_pkg::pay_t       out_payload,
  output logic [1:0]          status,
  output mpq_pkg::cnt_t       occupancy
);
  import mpq_pkg::*;

  pri_t      entry_pri [DEPTH];
  pay_t      entry_pay [DEPTH];
  cnt_t      count;

  cmd_code_t op_reg;
  pri_t      pri_reg;
  pay_t      pay_reg;
  idx_t      best_idx;

  pri_t      node_pri [LEVELS+1][LEAVES];
  idx_t      node_idx [LEVELS+1][LEAVES];
  logic      node_vld [LEVELS+1][LEAVES];

  logic      is_full;
  logic      is_empty;
  idx_t      tail_idx;

  assign is_full   = (count == CNT_W'(DEPTH));
  assign is_empty  = (count == '0);
  assign tail_idx  = count[IDX_W-1:0];
  assign dp_stat.slot_free = !rsp_valid || rsp_ready;
  assign occupancy = count;

  // Compare tree: the right child wins only on a strictly higher priority,
  // so the earlier entry keeps ties.
  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      if (i < DEPTH) begin
        node_pri[0][i] = entry_pri[i];
        node_vld[0][i] = (CNT_W'(i) < count);
      end else begin
        node_pri[0][i] = '0;
        node_vld[0][i] = 1'b0;
      end
      node_idx[0][i] = IDX_W'(i);
    end
    for (int l = 0; l < LEVELS; l++) begin
      for (int n = 0; n < LEAVES; n++) begin
        if (n < LEAVES / 2) begin
          if (node_vld[l][2*n+1] &&
              (!node_vld[l][2*n] || node_pri[l][2*n+1] > node_pri[l][2*n])) begin
            node_pri[l+1][n] = node_pri[l][2*n+1];
            node_idx[l+1][n] = node_idx[l][2*n+1];
          end else begin
            node_pri[l+1][n] = node_pri[l][2*n];
            node_idx[l+1][n] = node_idx[l][2*n];
          end
          node_vld[l+1][n] = node_vld[l][2*n] || node_vld[l][2*n+1];
        end else begin
          node_pri[l+1][n] = '0;
          node_idx[l+1][n] = '0;
          node_vld[l+1][n] = 1'b0;
        end
      end
    end
  end

  // request fields and search result
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      op_reg  <= cmd_code_t'(command);
      pri_reg <= priority_req;
      pay_reg <= payload;
    end
    if (dp_cmd.search) begin
      best_idx <= node_idx[LEVELS][0];
    end
  end

  // entry storage: append at the tail, close the gap on extract
  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      if (op_reg == CMD_ADD) begin
        if (!is_full) begin
          entry_pri[tail_idx] <= pri_reg;
          entry_pay[tail_idx] <= pay_reg;
        end
      end else if (!is_empty) begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          if (IDX_W'(i) >= best_idx) begin
            entry_pri[i] <= entry_pri[i+1];
            entry_pay[i] <= entry_pay[i+1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (dp_cmd.exec) begin
      if (op_reg == CMD_ADD) begin
        if (!is_full) begin
          count <= count + 1'b1;
        end
      end else if (!is_empty) begin
        count <= count - 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (dp_cmd.exec) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      if (op_reg == CMD_EXTRACT && !is_empty) begin
        out_valid    <= 1'b1;
        out_priority <= entry_pri[best_idx];
        out_payload  <= entry_pay[best_idx];
        status       <= ST_OK;
      end else begin
        out_valid    <= 1'b0;
        out_priority <= '0;
        out_payload  <= '0;
        if (op_reg == CMD_EXTRACT) begin
          status <= ST_EMPTY;
        end else if (is_full) begin
          status <= ST_FULL;
        end else begin
          status <= ST_OK;
        end
      end
    end
  end

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.exec && op_reg == CMD_ADD && !is_full |=> count == $past(count) + 1'b1)
    else $error("add did not grow the queue");

  a_extract_result: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.exec && op_reg == CMD_EXTRACT && !is_empty
      |=> out_valid && status == ST_OK && count == $past(count) - 1'b1)
    else $error("extract did not deliver an entry");

  a_exec_loads_result: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.exec |=> rsp_valid)
    else $error("executed request left no result");

endmodule

/* hw/rtl/max_priority_queue.sv */
// ----------------------------------------------------------------------------
// max_priority_queue
// Bounded priority queue kept in arrival order: add appends at the tail,
// extract removes the highest priority entry (earliest on a tie).
// ----------------------------------------------------------------------------
//
//   channel   handshake              fields
//   --------  ---------------------  ----------------------------------------
//   request   cmd_valid / cmd_ready  command, priority_req, payload
//   result    rsp_valid / rsp_ready  out_valid, out_priority, out_payload,
//                                    status, occupancy
//
// Steps: a request passes a search step, which registers the winner of the
//   max-compare tree over all entries, and an apply step; the next request
//   is accepted in the apply step of the one before it.
// Reset: clears the entry count, the sequencer and the result register;
//   entry contents are left as they are and are never read until written.
// Stalls: a finished result waits in the result register; one more request
//   is accepted and searched, and holds in its apply step until the result
//   register frees.
// ----------------------------------------------------------------------------
module max_priority_queue (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  logic                command,
  input  mpq_pkg::pri_t       priority_req,
  input  mpq_pkg::pay_t       payload,
  // result channel
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output logic                out_valid,
  output mpq_pkg::pri_t       out_priority,
  output mpq_pkg::pay_t       out_payload,
  output logic [1:0]          status,
  output mpq_pkg::cnt_t       occupancy
);
  import mpq_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer: accept, search, apply
  mpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  // storage, compare tree, gap close and result register
  mpq_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .dp_cmd       (dp_cmd),
    .dp_stat      (dp_stat),
    .command      (command),
    .priority_req (priority_req),
    .payload      (payload),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .out_valid    (out_valid),
    .out_priority (out_priority),
    .out_payload  (out_payload),
    .status       (status),
    .occupancy    (occupancy)
  );

endmodule
